// ===== sv/trie_string_id_assigner_assert.svh =====
// Assertion macros for the trie string ID assigner checker.
// Needs no package; the caller supplies clock, reset and expressions.
`ifndef TRIE_STRING_ID_ASSIGNER_ASSERT_SVH
`define TRIE_STRING_ID_ASSIGNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSIA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trie_string_id_assigner: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TSIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trie_string_id_assigner: next-cycle check failed");

`endif

// ===== sv/tsia_pkg.sv =====
// Shared types, constants and datapath operation codes for the trie string ID assigner.
// No dependencies; every other file but the assertion header imports this package.
package tsia_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int AW         = $clog2(NODE_COUNT);
  localparam int NFW        = AW + 1;
  localparam int SYM_W      = 8;
  localparam int ID_W       = 12;
  localparam int CW         = (AW > ID_W) ? AW : ID_W;
  localparam int ST_W       = 2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_PREFIX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  localparam logic [AW-1:0] ROOT_NODE = AW'(1);
  localparam logic [NFW-1:0] FIRST_FREE = NFW'(2);

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] string_id;
    logic [ST_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] ch;
    logic [AW-1:0]    sibling;
    logic [CW-1:0]    child;
  } node_t;

  localparam int OP_W = 5;
  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_NONE        = 5'd0;
  localparam op_t OP_INIT        = 5'd1;
  localparam op_t OP_ACCEPT      = 5'd2;
  localparam op_t OP_KILL        = 5'd3;
  localparam op_t OP_RD_NEXT     = 5'd4;
  localparam op_t OP_TAKE        = 5'd5;
  localparam op_t OP_CLAIM       = 5'd6;
  localparam op_t OP_LINK_SIB    = 5'd7;
  localparam op_t OP_ALLOC_SIB   = 5'd8;
  localparam op_t OP_SET_FULL    = 5'd9;
  localparam op_t OP_DESCEND     = 5'd10;
  localparam op_t OP_LINK_CHILD  = 5'd11;
  localparam op_t OP_ALLOC_CHILD = 5'd12;
  localparam op_t OP_RES_FULL    = 5'd13;
  localparam op_t OP_RES_PREFIX  = 5'd14;
  localparam op_t OP_RES_NEW     = 5'd15;
  localparam op_t OP_RD_CUR      = 5'd16;
  localparam op_t OP_RES_LOOKUP  = 5'd17;
  localparam op_t OP_EMIT        = 5'd18;

  typedef struct packed {
    logic full;
    logic cur_zero;
    logic last;
    logic sym_zero;
    logic created;
    logic first_dead;
    logic hit;
    logic head_free;
    logic no_sib;
    logic nodes_out;
    logic has_child;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== sv/tsia_ctrl.sv =====
// Controller state machine for the trie string ID assigner.
// Depends on tsia_pkg; drives datapath operation codes from datapath status.
module tsia_ctrl import tsia_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output op_t        op
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CHK     = 4'd2;
  localparam logic [3:0] S_ALLOC_S = 4'd3;
  localparam logic [3:0] S_CHILD   = 4'd4;
  localparam logic [3:0] S_ALLOC_C = 4'd5;
  localparam logic [3:0] S_FINISH  = 4'd6;
  localparam logic [3:0] S_LOOKUP  = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_INIT: begin
        op        = OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_ACCEPT;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        priority if (st.full || st.cur_zero) begin
          state_nxt = S_FINISH;
        end else if (st.sym_zero || st.first_dead) begin
          op        = OP_KILL;
          state_nxt = S_FINISH;
        end else if (st.hit) begin
          op        = OP_TAKE;
          state_nxt = S_CHILD;
        end else if (st.head_free) begin
          op        = OP_CLAIM;
          state_nxt = S_CHILD;
        end else if (st.no_sib && st.nodes_out) begin
          op        = OP_SET_FULL;
          state_nxt = S_FINISH;
        end else if (st.no_sib) begin
          op        = OP_LINK_SIB;
          state_nxt = S_ALLOC_S;
        end else begin
          op        = OP_RD_NEXT;
        end
      end
      S_ALLOC_S: begin
        op        = OP_ALLOC_SIB;
        state_nxt = S_CHILD;
      end
      S_CHILD: begin
        priority if (st.has_child) begin
          op        = OP_DESCEND;
          state_nxt = S_FINISH;
        end else if (st.nodes_out) begin
          op        = OP_SET_FULL;
          state_nxt = S_FINISH;
        end else begin
          op        = OP_LINK_CHILD;
          state_nxt = S_ALLOC_C;
        end
      end
      S_ALLOC_C: begin
        op        = OP_ALLOC_CHILD;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        priority if (!st.last) begin
          state_nxt = S_IDLE;
        end else if (st.full) begin
          op        = OP_RES_FULL;
          state_nxt = S_EMIT;
        end else if (st.cur_zero) begin
          op        = OP_RES_PREFIX;
          state_nxt = S_EMIT;
        end else if (st.created) begin
          op        = OP_RES_NEW;
          state_nxt = S_EMIT;
        end else begin
          op        = OP_RD_CUR;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        op        = OP_RES_LOOKUP;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          op        = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/tsia_dp.sv =====
// Datapath for the trie string ID assigner: node memory, trie registers, output register.
// Depends on tsia_pkg; executes one operation code per cycle from tsia_ctrl.
module tsia_dp import tsia_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  op_t        op,
  input  in_item_t   in_data,
  input  logic       out_stall,
  output logic       out_valid,
  output out_item_t  out_data,
  output dp_status_t st
);

  node_t mem [NODE_COUNT];

  node_t            rdata_r;
  node_t            word_r;
  logic [SYM_W-1:0] sym_r;
  logic             last_r;
  logic [AW-1:0]    pos_r;
  logic             first_r;
  out_item_t        res_r;
  out_item_t        out_data_r;

  logic [AW-1:0]  cursor_r, cursor_nxt;
  logic [NFW-1:0] nfn_r, nfn_nxt;
  logic [ID_W-1:0] leaf_r, leaf_nxt;
  logic           created_r, created_nxt;
  logic           full_r, full_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  node_t         wr_node;
  logic [AW-1:0] rd_addr;

  // Write port: one node word per cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_node = rdata_r;
    unique case (op)
      OP_INIT: begin
        wr_en   = 1'b1;
        wr_addr = ROOT_NODE;
        wr_node = '0;
      end
      OP_CLAIM: begin
        wr_en      = 1'b1;
        wr_node.ch = sym_r;
      end
      OP_LINK_SIB: begin
        wr_en           = 1'b1;
        wr_node.sibling = nfn_r[AW-1:0];
      end
      OP_ALLOC_SIB: begin
        wr_en      = 1'b1;
        wr_addr    = nfn_r[AW-1:0];
        wr_node    = '0;
        wr_node.ch = sym_r;
      end
      OP_LINK_CHILD: begin
        wr_en         = 1'b1;
        wr_node       = word_r;
        wr_node.child = CW'(nfn_r);
      end
      OP_ALLOC_CHILD: begin
        wr_en   = 1'b1;
        wr_addr = nfn_r[AW-1:0];
        wr_node = '0;
      end
      OP_RES_NEW: begin
        wr_en         = 1'b1;
        wr_addr       = cursor_r;
        wr_node       = '0;
        wr_node.child = CW'(leaf_r);
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = (op == OP_RD_NEXT) ? rdata_r.sibling : cursor_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_node;
    end
  end

  always_comb begin
    cursor_nxt    = cursor_r;
    nfn_nxt       = nfn_r;
    leaf_nxt      = leaf_r;
    created_nxt   = created_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (op)
      OP_KILL: cursor_nxt = '0;
      OP_CLAIM: created_nxt = 1'b1;
      OP_SET_FULL: full_nxt = 1'b1;
      OP_ALLOC_SIB: begin
        nfn_nxt     = nfn_r + NFW'(1);
        created_nxt = 1'b1;
      end
      OP_DESCEND: cursor_nxt = word_r.child[AW-1:0];
      OP_ALLOC_CHILD: begin
        cursor_nxt = nfn_r[AW-1:0];
        nfn_nxt    = nfn_r + NFW'(1);
        full_nxt   = (nfn_r == NFW'(NODE_COUNT - 1));
      end
      OP_RES_FULL, OP_RES_PREFIX, OP_RES_LOOKUP: begin
        cursor_nxt  = ROOT_NODE;
        created_nxt = 1'b0;
      end
      OP_RES_NEW: begin
        cursor_nxt  = ROOT_NODE;
        created_nxt = 1'b0;
        leaf_nxt    = leaf_r + ID_W'(1);
      end
      OP_EMIT: out_valid_nxt = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= ROOT_NODE;
      nfn_r       <= FIRST_FREE;
      leaf_r      <= '0;
      created_r   <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r    <= cursor_nxt;
      nfn_r       <= nfn_nxt;
      leaf_r      <= leaf_nxt;
      created_r   <= created_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_ACCEPT: begin
        sym_r   <= in_data.symbol;
        last_r  <= in_data.last;
        pos_r   <= cursor_r;
        first_r <= 1'b1;
      end
      OP_RD_NEXT: begin
        pos_r   <= rdata_r.sibling;
        first_r <= 1'b0;
      end
      OP_TAKE: word_r <= rdata_r;
      OP_CLAIM: word_r <= wr_node;
      OP_ALLOC_SIB: begin
        word_r <= wr_node;
        pos_r  <= nfn_r[AW-1:0];
      end
      OP_RES_FULL: res_r <= '{string_id: '0, status: ST_FULL};
      OP_RES_PREFIX: res_r <= '{string_id: '0, status: ST_PREFIX};
      OP_RES_NEW: res_r <= '{string_id: leaf_r, status: ST_OK};
      OP_RES_LOOKUP: begin
        if (rdata_r.ch != '0) begin
          res_r <= '{string_id: '0, status: ST_PREFIX};
        end else begin
          res_r <= '{string_id: rdata_r.child[ID_W-1:0], status: ST_OK};
        end
      end
      OP_EMIT: out_data_r <= res_r;
      default: begin
      end
    endcase
  end

  assign st.full       = full_r;
  assign st.cur_zero   = (cursor_r == '0);
  assign st.last       = last_r;
  assign st.sym_zero   = (sym_r == '0);
  assign st.created    = created_r;
  assign st.first_dead = first_r && !created_r && (pos_r != ROOT_NODE) && (rdata_r.ch == '0);
  assign st.hit        = (rdata_r.ch == sym_r);
  assign st.head_free  = (rdata_r.ch == '0);
  assign st.no_sib     = (rdata_r.sibling == '0);
  assign st.nodes_out  = (nfn_r >= NFW'(NODE_COUNT));
  assign st.has_child  = (word_r.child != '0);
  assign st.out_busy   = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/trie_string_id_assigner.sv =====
// Top level of the trie string ID assigner: joins the controller and the datapath.
// Depends on tsia_pkg, tsia_ctrl and tsia_dp.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_stall  | in_item_t  {symbol, last}
//   out_    | output    | out_valid/out_stall| out_item_t {string_id, status}
//
// A character that walks its level passes S_IDLE, S_CHK, S_CHILD and S_FINISH,
// staying in S_CHK for each sibling hop on that level, and visits S_ALLOC_S or
// S_ALLOC_C for each node allocated (at most two). The registered read of the
// node memory sets one hop per cycle. A character that marks its string dead,
// or arrives once the string is dead or the store is full, skips S_CHILD.
// A string end adds S_EMIT after a new, failed or full result, or S_LOOKUP and
// S_EMIT for the lookup of a stored string, plus any wait for the output register.
// After reset in_stall stays high for one cycle while the root node is
// cleared; all other nodes are written whole when allocated.
// A stalled result holds in the output register; the next character is still
// taken, and only a second result waits for the first transfer.
module trie_string_id_assigner import tsia_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  op_t        op;
  dp_status_t st;

  // Sequence the walk: read, compare, link, allocate, descend, report.
  tsia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  // Hold the node store, trie state and the result register.
  tsia_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .st        (st)
  );

endmodule

// ===== sv/tsia_checker.sv =====
// Port-level checker for the trie string ID assigner, bound to the top level.
// Depends on tsia_pkg and trie_string_id_assigner_assert.svh.
`include "trie_string_id_assigner_assert.svh"

module tsia_checker import tsia_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic status_known;
  logic res_failed;
  logic out_held;

  assign status_known = (out_data.status == ST_OK) || (out_data.status == ST_PREFIX) ||
                        (out_data.status == ST_FULL);
  assign res_failed   = out_valid && (out_data.status != ST_OK);
  assign out_held     = out_valid && out_stall;

  // Items are handled one at a time: a transfer is followed by a stall.
  `TSIA_ASSERT_NEXT(a_in_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)

  `TSIA_ASSERT_SAME(a_status_code, clk, rst_n, out_valid, status_known)

  // Failed strings carry no ID.
  `TSIA_ASSERT_SAME(a_id_zero_on_error, clk, rst_n, res_failed, out_data.string_id == '0)

  `TSIA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_data))

endmodule

bind trie_string_id_assigner tsia_checker u_tsia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
